// ----- src/swas_pkg.sv -----
// swas_pkg: types, constants and helpers shared by the ARQ sender files
`timescale 1ns / 1ps
package swas_pkg;

   // window geometry
   localparam int MAX_WINDOW = 32;
   localparam int MIN_WINDOW = 10;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int WIN_W      = 6;
   localparam int SEQ_W      = 6;
   localparam int FRAME_W    = 24;
   localparam int FBIT_W     = $clog2(FRAME_W);

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES = 2'd1;

   // reset value of the window size register
   localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd10;

   // command codes
   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_NACK    = 2'd2,
      CMD_TIMEOUT = 2'd3
   } cmd_type;

   // request word
   typedef struct packed {
      logic [1:0]       command;
      logic [SEQ_W-1:0] ack_seq;
   } req_type;

   // response word
   typedef struct packed {
      logic               send_valid;
      logic [SLOT_W-1:0]  slot_index;
      logic [SEQ_W-1:0]   seq_number;
      logic [FRAME_W-1:0] frame_number;
      logic               transfer_done;
      logic               ack_miss;
      logic               last;
   } rsp_type;

   // clamp the programmed size into the supported window range
   function automatic logic [WIN_W-1:0] win_clamp(input logic [WIN_W-1:0] ws);
      logic [WIN_W-1:0] w;
      w = ws;
      if (ws < WIN_W'(MIN_WINDOW)) w = WIN_W'(MIN_WINDOW);
      if (ws > WIN_W'(MAX_WINDOW)) w = WIN_W'(MAX_WINDOW);
      return w;
   endfunction

endpackage

// ----- src/sliding_window_arq_sender_top.sv -----
// sliding window arq sender: slot walker, frame store and response staging
// One slot is visited per cycle by the shared walker, unless a waiting response word stalls it.
// Throughput: one command at a time; rsp_stall holds the walker while a word waits.
// A window_size write recomputes the sequence counter bit-serially over the 24 frame bits.
// Reset (synchronous, active high) empties every slot and clears all pointers and counters.
`timescale 1ns / 1ps
module sliding_window_arq_sender_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  swas_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output swas_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swas_pkg::CSR_DATA_W-1:0]      csr_data
);

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MOD    = 8'b0000_0010,
      ST_FILL   = 8'b0000_0100,
      ST_WALK   = 8'b0000_1000,
      ST_REFILL = 8'b0001_0000,
      ST_SKIP   = 8'b0010_0000,
      ST_NACK   = 8'b0100_0000,
      ST_TOUT   = 8'b1000_0000
   } state_type;

   localparam int SW = swas_pkg::SLOT_W;
   localparam int WW = swas_pkg::WIN_W;
   localparam int QW = swas_pkg::SEQ_W;
   localparam int FW = swas_pkg::FRAME_W;
   localparam int BW = swas_pkg::FBIT_W;

   state_type               state_ff, state_in;
   logic [WW-1:0]           window_size_ff, window_size_in;
   logic [FW-1:0]           total_frames_ff, total_frames_in;
   logic [swas_pkg::MAX_WINDOW-1:0] slot_valid_ff, slot_valid_in;
   logic [SW-1:0]           top_ff, top_in;
   logic [SW-1:0]           p_ff, p_in;
   logic [WW-1:0]           i_ff, i_in;
   logic [FW-1:0]           next_frame_ff, next_frame_in;
   logic [QW-1:0]           next_seq_ff, next_seq_in;
   logic [QW-1:0]           outstanding_ff, outstanding_in;
   logic                    more_ff, more_in;
   logic [QW-1:0]           ack_ff, ack_in;
   logic [QW-1:0]           mod_rem_ff, mod_rem_in;
   logic [BW-1:0]           mod_cnt_ff, mod_cnt_in;
   swas_pkg::rsp_type       pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;
   swas_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // frame store, no reset: read only where the valid bit is set
   logic [QW-1:0]           seq_mem   [swas_pkg::MAX_WINDOW];
   logic [FW-1:0]           frame_mem [swas_pkg::MAX_WINDOW];
   logic                    mem_we;

   logic [WW-1:0]           w_eff;
   logic [WW:0]             two_w;
   logic [SW-1:0]           nxt_p;
   logic [SW-1:0]           top_clamp;
   logic [QW-1:0]           seq_inc;
   logic [QW-1:0]           ack_rem;
   logic                    have_frame;
   logic                    rd_valid;
   logic [QW-1:0]           rd_seq;
   logic [FW-1:0]           rd_frame;
   logic                    out_free;
   logic                    i_done;
   logic                    req_acc;
   logic                    csr_acc;
   logic [WW:0]             mod_t;
   logic [WW:0]             mod_sub;

   // emit / finish strobes from the sequencer
   logic                    emit;
   logic [SW-1:0]           emit_slot;
   logic [QW-1:0]           emit_seq;
   logic [FW-1:0]           emit_frame;
   logic                    fin;
   logic                    fin_done;
   logic                    fin_miss;
   swas_pkg::rsp_type       fin_word;

   // window arithmetic
   assign w_eff      = swas_pkg::win_clamp(window_size_ff);
   assign two_w      = {w_eff, 1'b0};
   assign nxt_p      = (({1'b0, p_ff} + WW'(1)) == w_eff) ? '0 : p_ff + SW'(1);
   assign top_clamp  = ({1'b0, top_ff} >= w_eff) ? '0 : top_ff;
   assign seq_inc    = (({1'b0, next_seq_ff} + (WW+1)'(1)) == two_w) ? '0
                                                                  : next_seq_ff + QW'(1);
   assign ack_rem    = (outstanding_ff == '0) ? '0 : outstanding_ff - QW'(1);
   assign have_frame = next_frame_ff < total_frames_ff;
   assign i_done     = i_ff == w_eff;

   // slot read at the walk pointer
   assign rd_valid = slot_valid_ff[p_ff];
   assign rd_seq   = seq_mem[p_ff];
   assign rd_frame = frame_mem[p_ff];

   // handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = state_ff == ST_IDLE;
   assign req_stall = (state_ff != ST_IDLE) || csr_valid;
   assign req_acc   = req_valid && !req_stall;
   assign csr_acc   = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one restoring step of next_frame mod 2W
   assign mod_t   = {mod_rem_ff, next_frame_ff[mod_cnt_ff]};
   assign mod_sub = (mod_t >= two_w) ? mod_t - two_w : mod_t;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      window_size_in  = window_size_ff;
      total_frames_in = total_frames_ff;
      slot_valid_in   = slot_valid_ff;
      top_in          = top_ff;
      p_in            = p_ff;
      i_in            = i_ff;
      next_frame_in   = next_frame_ff;
      next_seq_in     = next_seq_ff;
      outstanding_in  = outstanding_ff;
      more_in         = more_ff;
      ack_in          = ack_ff;
      mod_rem_in      = mod_rem_ff;
      mod_cnt_in      = mod_cnt_ff;
      mem_we          = 1'b0;
      emit            = 1'b0;
      emit_slot       = p_ff;
      emit_seq        = rd_seq;
      emit_frame      = rd_frame;
      fin             = 1'b0;
      fin_done        = 1'b0;
      fin_miss        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               case (csr_index)
                  swas_pkg::CSR_WINDOW_SIZE: begin
                     window_size_in = csr_data[WW-1:0];
                     mod_rem_in     = '0;
                     mod_cnt_in     = BW'(FW - 1);
                     state_in       = ST_MOD;
                  end
                  swas_pkg::CSR_TOTAL_FRAMES: begin
                     total_frames_in = csr_data[FW-1:0];
                  end
                  default: begin
                  end
               endcase
            end else if (req_acc) begin
               i_in = '0;
               case (swas_pkg::cmd_type'(req_data.command))
                  swas_pkg::CMD_START: begin
                     slot_valid_in  = '0;
                     top_in         = '0;
                     p_in           = '0;
                     next_frame_in  = '0;
                     next_seq_in    = '0;
                     outstanding_in = '0;
                     state_in       = ST_FILL;
                  end
                  swas_pkg::CMD_ACK: begin
                     top_in   = top_clamp;
                     p_in     = top_clamp;
                     ack_in   = req_data.ack_seq;
                     state_in = (outstanding_ff > QW'(1)) ? ST_WALK : ST_REFILL;
                  end
                  swas_pkg::CMD_NACK: begin
                     top_in   = top_clamp;
                     p_in     = top_clamp;
                     state_in = ST_NACK;
                  end
                  default: begin
                     top_in   = top_clamp;
                     p_in     = '0;
                     state_in = ST_TOUT;
                  end
               endcase
            end
         end
         // bit-serial remainder after a window size change
         ST_MOD: begin
            mod_rem_in = mod_sub[QW-1:0];
            mod_cnt_in = mod_cnt_ff - BW'(1);
            if (mod_cnt_ff == '0) begin
               next_seq_in = mod_sub[QW-1:0];
               state_in    = ST_IDLE;
            end
         end
         // load frames into slots from slot zero
         ST_FILL: begin
            if (out_free) begin
               if (i_done) begin
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end else if (!have_frame) begin
                  more_in  = 1'b0;
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  mem_we            = 1'b1;
                  slot_valid_in[p_ff] = 1'b1;
                  next_frame_in     = next_frame_ff + FW'(1);
                  next_seq_in       = seq_inc;
                  outstanding_in    = outstanding_ff + QW'(1);
                  more_in           = 1'b1;
                  emit              = 1'b1;
                  emit_seq          = next_seq_ff;
                  emit_frame        = next_frame_ff;
                  p_in              = nxt_p;
                  i_in              = i_ff + WW'(1);
               end
            end
         end
         // resend valid slots until the acked number turns up or the window runs out
         ST_WALK: begin
            if (out_free) begin
               if (i_done) begin
                  fin      = 1'b1;
                  fin_miss = 1'b1;
                  state_in = ST_IDLE;
               end else if (rd_valid && (rd_seq == ack_ff)) begin
                  state_in = ST_REFILL;
               end else begin
                  emit = rd_valid;
                  p_in = nxt_p;
                  i_in = i_ff + WW'(1);
               end
            end
         end
         // refill or retire the acked slot
         ST_REFILL: begin
            if (out_free) begin
               outstanding_in = ack_rem;
               more_in        = more_ff && have_frame;
               if (more_ff && have_frame) begin
                  mem_we              = 1'b1;
                  slot_valid_in[p_ff] = 1'b1;
                  next_frame_in       = next_frame_ff + FW'(1);
                  next_seq_in         = seq_inc;
                  outstanding_in      = ack_rem + QW'(1);
                  emit                = 1'b1;
                  emit_seq            = next_seq_ff;
                  emit_frame          = next_frame_ff;
               end else begin
                  slot_valid_in[p_ff] = 1'b0;
               end
               top_in   = nxt_p;
               p_in     = nxt_p;
               i_in     = '0;
               state_in = ST_SKIP;
            end
         end
         // advance top to the next occupied slot
         ST_SKIP: begin
            if (out_free) begin
               if (i_done) begin
                  fin      = 1'b1;
                  fin_done = 1'b1;
                  state_in = ST_IDLE;
               end else if (rd_valid) begin
                  top_in   = p_ff;
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  p_in = nxt_p;
                  i_in = i_ff + WW'(1);
               end
            end
         end
         // resend the top slot
         ST_NACK: begin
            if (out_free) begin
               emit     = rd_valid;
               top_in   = nxt_p;
               p_in     = nxt_p;
               i_in     = '0;
               state_in = ST_SKIP;
            end
         end
         // resend every occupied slot
         ST_TOUT: begin
            if (out_free) begin
               if (i_done) begin
                  fin      = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  emit = rd_valid;
                  p_in = nxt_p;
                  i_in = i_ff + WW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // closing word: held send or an empty word, with the status flags
   always_comb begin
      fin_word               = pend_valid_ff ? pend_ff : '0;
      fin_word.transfer_done = fin_done;
      fin_word.ack_miss      = fin_miss;
      fin_word.last          = 1'b1;
   end

   // one send is held back so the closing flags can land on it
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_data_in  = pend_ff;
            rsp_valid_in = 1'b1;
         end
         pend_in.send_valid    = 1'b1;
         pend_in.slot_index    = emit_slot;
         pend_in.seq_number    = emit_seq;
         pend_in.frame_number  = emit_frame;
         pend_in.transfer_done = 1'b0;
         pend_in.ack_miss      = 1'b0;
         pend_in.last          = 1'b0;
         pend_valid_in         = 1'b1;
      end else if (fin) begin
         rsp_data_in   = fin_word;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         window_size_ff  <= swas_pkg::WINDOW_RESET;
         total_frames_ff <= '0;
         slot_valid_ff   <= '0;
         top_ff          <= '0;
         p_ff            <= '0;
         i_ff            <= '0;
         next_frame_ff   <= '0;
         next_seq_ff     <= '0;
         outstanding_ff  <= '0;
         more_ff         <= 1'b0;
         mod_cnt_ff      <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         window_size_ff  <= window_size_in;
         total_frames_ff <= total_frames_in;
         slot_valid_ff   <= slot_valid_in;
         top_ff          <= top_in;
         p_ff            <= p_in;
         i_ff            <= i_in;
         next_frame_ff   <= next_frame_in;
         next_seq_ff     <= next_seq_in;
         outstanding_ff  <= outstanding_in;
         more_ff         <= more_in;
         mod_cnt_ff      <= mod_cnt_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ack_ff      <= ack_in;
      mod_rem_ff  <= mod_rem_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // frame store write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         seq_mem[p_ff]   <= next_seq_ff;
         frame_mem[p_ff] <= next_frame_ff;
      end
   end

endmodule

// ----- src/swas_checker.sv -----
// swas_checker: port-level checks on the response channel of the ARQ sender
`timescale 1ns / 1ps
module swas_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input swas_pkg::rsp_type rsp_data
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // a word with no send is always the closing word and carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |->
         rsp_data.last && (rsp_data.slot_index == '0) && (rsp_data.seq_number == '0)
         && (rsp_data.frame_number == '0))
      else $error("empty response word is not a clean closing word");

   // status flags only ride on the closing word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.transfer_done || rsp_data.ack_miss) |-> rsp_data.last)
      else $error("status flag on a non-closing word");

   // a missed ack never reports an empty window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ack_miss |-> !rsp_data.transfer_done)
      else $error("ack miss and transfer done together");

endmodule

bind sliding_window_arq_sender_top swas_checker u_swas_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/tb_sliding_window_arq_sender_top.sv -----
// testbench for the sliding window arq sender: directed table, then random traffic
`timescale 1ns / 1ps
module tb_sliding_window_arq_sender_top;

   localparam int MAX_WORDS   = 33;
   localparam int SETTLE      = 2 * swas_pkg::MAX_WINDOW + 16;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 48;
   localparam int PRINT_LIMIT = 40;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   swas_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   swas_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [swas_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [swas_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int items_sent         = 0;
   int words_checked      = 0;
   int misses_seen        = 0;
   int drains_seen        = 0;

   // shadow copy of the window and its registers
   logic [swas_pkg::WIN_W-1:0]   cfg_window = swas_pkg::WINDOW_RESET;
   logic [swas_pkg::FRAME_W-1:0] cfg_total  = '0;
   bit                           slot_busy  [swas_pkg::MAX_WINDOW];
   logic [swas_pkg::SEQ_W-1:0]   slot_seqno [swas_pkg::MAX_WINDOW];
   logic [swas_pkg::FRAME_W-1:0] slot_fno   [swas_pkg::MAX_WINDOW];
   int unsigned                  top_slot;
   logic [swas_pkg::FRAME_W-1:0] next_fno;
   logic [5:0]                   in_flight;
   bit                           more_frames;

   // words of the command being predicted, and words still to arrive
   swas_pkg::rsp_type cmd_words[$];
   swas_pkg::rsp_type due_words[$];

   // directed table
   typedef struct {
      bit                           is_cfg;
      swas_pkg::req_type            word;
      bit                           typed;
      bit                           typed_done;
      logic [swas_pkg::WIN_W-1:0]   ws;
      logic [swas_pkg::FRAME_W-1:0] tf;
   } step_row_type;
   step_row_type plan_rows[$];

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sliding_window_arq_sender_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // window size in use after clamping
   function automatic int unsigned span();
      int unsigned w;
      w = cfg_window;
      if (w < swas_pkg::MIN_WINDOW) w = swas_pkg::MIN_WINDOW;
      if (w > swas_pkg::MAX_WINDOW) w = swas_pkg::MAX_WINDOW;
      return w;
   endfunction

   // one word per frame sent, dropped past the word limit
   function automatic void order_send(int unsigned slot);
      swas_pkg::rsp_type w;
      w              = '0;
      w.send_valid   = 1'b1;
      w.slot_index   = swas_pkg::SLOT_W'(slot);
      w.seq_number   = slot_seqno[slot];
      w.frame_number = slot_fno[slot];
      if (cmd_words.size() < MAX_WORDS) cmd_words.push_back(w);
   endfunction

   // status flags ride on the final word of a command
   function automatic void close_cmd(bit done, bit miss);
      swas_pkg::rsp_type w;
      if (cmd_words.size() == 0) cmd_words.push_back('0);
      w               = cmd_words[cmd_words.size() - 1];
      w.transfer_done = done;
      w.ack_miss      = miss;
      w.last          = 1'b1;
      cmd_words[cmd_words.size() - 1] = w;
   endfunction

   // load the next frame into a slot while the source still has one
   function automatic bit load_frame(int unsigned slot, int unsigned w);
      int unsigned f;
      f = next_fno;
      if (next_fno >= cfg_total) return 1'b0;
      slot_busy[slot]  = 1'b1;
      slot_seqno[slot] = swas_pkg::SEQ_W'(f % (2 * w));
      slot_fno[slot]   = next_fno;
      next_fno         = next_fno + 1'b1;
      in_flight        = in_flight + 1'b1;
      return 1'b1;
   endfunction

   // move the top to the first busy slot; 1 when the window is empty
   function automatic bit window_drained(int unsigned w);
      int unsigned p;
      p = top_slot;
      for (int i = 0; i < w; i++) begin
         if (slot_busy[p]) begin
            top_slot = p;
            return 1'b0;
         end
         p = (p + 1) % w;
      end
      return 1'b1;
   endfunction

   // work out the words one command produces and update the shadow window
   function automatic void plan_sends(swas_pkg::req_type r);
      int unsigned w;
      int unsigned p;
      logic [5:0]  rem;
      bit          found;
      w = span();
      cmd_words.delete();
      if (top_slot >= w) top_slot = 0;
      case (swas_pkg::cmd_type'(r.command))
         swas_pkg::CMD_START: begin
            for (int i = 0; i < swas_pkg::MAX_WINDOW; i++) slot_busy[i] = 1'b0;
            top_slot  = 0;
            next_fno  = '0;
            in_flight = '0;
            for (int i = 0; i < w; i++) begin
               more_frames = load_frame(i, w);
               if (!more_frames) break;
               order_send(i);
            end
            top_slot = 0;
            close_cmd(1'b0, 1'b0);
         end
         swas_pkg::CMD_ACK: begin
            rem   = (in_flight == 0) ? '0 : in_flight - 1'b1;
            p     = top_slot;
            found = 1'b0;
            // with one frame outstanding the top is taken as acked, no search
            if (rem != 0) begin
               for (int i = 0; i < w; i++) begin
                  if (slot_busy[p] && slot_seqno[p] == r.ack_seq) begin
                     found = 1'b1;
                     break;
                  end
                  if (slot_busy[p]) order_send(p);
                  p = (p + 1) % w;
               end
            end
            if (rem != 0 && !found) begin
               // miss: resends stand, nothing else moves
               close_cmd(1'b0, 1'b1);
            end else begin
               in_flight = rem;
               top_slot  = p;
               if (more_frames) more_frames = load_frame(p, w);
               if (more_frames) order_send(p);
               else slot_busy[p] = 1'b0;
               top_slot = (p + 1) % w;
               close_cmd(window_drained(w), 1'b0);
            end
         end
         swas_pkg::CMD_NACK: begin
            if (slot_busy[top_slot]) order_send(top_slot);
            top_slot = (top_slot + 1) % w;
            close_cmd(window_drained(w), 1'b0);
         end
         swas_pkg::CMD_TIMEOUT: begin
            for (int i = 0; i < w; i++) if (slot_busy[i]) order_send(i);
            close_cmd(1'b0, 1'b0);
         end
         default: begin
         end
      endcase
   endfunction

   // ack number: mostly the top frame, sometimes deeper in the window, sometimes stray
   function automatic logic [swas_pkg::SEQ_W-1:0] pick_ack();
      int unsigned w;
      int unsigned t;
      int unsigned roll;
      int unsigned busy[$];
      w    = span();
      t    = (top_slot < w) ? top_slot : 0;
      roll = $urandom_range(0, 99);
      for (int i = 0; i < w; i++) if (slot_busy[i]) busy.push_back(i);
      if (roll < 55 && slot_busy[t]) return slot_seqno[t];
      if (roll < 85 && busy.size() != 0)
         return slot_seqno[busy[$urandom_range(0, busy.size() - 1)]];
      return swas_pkg::SEQ_W'($urandom_range(0, 63));
   endfunction

   function automatic void add_row(swas_pkg::cmd_type c, logic [swas_pkg::SEQ_W-1:0] a,
                                   bit typed = 1'b0, bit done = 1'b0);
      step_row_type s;
      s            = '{default: '0};
      s.word       = '{command: c, ack_seq: a};
      s.typed      = typed;
      s.typed_done = done;
      plan_rows.push_back(s);
   endfunction

   function automatic void add_cfg(logic [swas_pkg::WIN_W-1:0] ws,
                                   logic [swas_pkg::FRAME_W-1:0] tf);
      step_row_type s;
      s        = '{default: '0};
      s.is_cfg = 1'b1;
      s.ws     = ws;
      s.tf     = tf;
      plan_rows.push_back(s);
   endfunction

   // one line per mismatch
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t word %0d: %s got %0h want %0h", $time, words_checked, what, got, want);
      error_count++;
   endtask

   // compare one accepted word with the oldest one due
   task automatic check_word(swas_pkg::rsp_type got);
      swas_pkg::rsp_type want;
      if (due_words.size() == 0) begin
         report_mismatch("word with nothing due", 32'(got.last), 32'(1'b0));
         return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (want.ack_miss) misses_seen++;
      if (want.transfer_done) drains_seen++;
      if (got.send_valid !== want.send_valid)
         report_mismatch("send_valid", 32'(got.send_valid), 32'(want.send_valid));
      if (got.slot_index !== want.slot_index)
         report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
      if (got.seq_number !== want.seq_number)
         report_mismatch("seq_number", 32'(got.seq_number), 32'(want.seq_number));
      if (got.frame_number !== want.frame_number)
         report_mismatch("frame_number", 32'(got.frame_number), 32'(want.frame_number));
      if (got.transfer_done !== want.transfer_done)
         report_mismatch("transfer_done", 32'(got.transfer_done), 32'(want.transfer_done));
      if (got.ack_miss !== want.ack_miss)
         report_mismatch("ack_miss", 32'(got.ack_miss), 32'(want.ack_miss));
      if (got.last !== want.last)
         report_mismatch("last", 32'(got.last), 32'(want.last));
   endtask

   // response side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_word(rsp_data);
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // present one request word after an optional gap, predict once it is taken
   task automatic drive_req(swas_pkg::req_type r, bit typed, bit typed_done);
      swas_pkg::rsp_type w;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      plan_sends(r);
      if (typed) begin
         w               = '0;
         w.transfer_done = typed_done;
         w.last          = 1'b1;
         due_words.push_back(w);
      end else begin
         foreach (cmd_words[i]) due_words.push_back(cmd_words[i]);
      end
      items_sent++;
   endtask

   // wait for every due word, then let the walker settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write both registers one after the other while the block is idle
   task automatic program_window(logic [swas_pkg::WIN_W-1:0] ws,
                                 logic [swas_pkg::FRAME_W-1:0] tf);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= swas_pkg::CSR_WINDOW_SIZE;
      csr_data  <= swas_pkg::CSR_DATA_W'(ws);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_window = ws;
      csr_index <= swas_pkg::CSR_TOTAL_FRAMES;
      csr_data  <= tf;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_total = tf;
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin : stimulus
      swas_pkg::req_type            r;
      bit                           drained;
      int unsigned                  roll;
      logic [swas_pkg::WIN_W-1:0]   ws;
      logic [swas_pkg::FRAME_W-1:0] tf;

      for (int i = 0; i < swas_pkg::MAX_WINDOW; i++) begin
         slot_busy[i]  = 1'b0;
         slot_seqno[i] = '0;
         slot_fno[i]   = '0;
      end
      top_slot           = 0;
      next_fno           = '0;
      in_flight          = '0;
      more_frames        = 1'b0;
      sender_idle_pct    = 35;
      receiver_stall_pct = 56;

      // straight after reset: empty window, no frames to read
      add_row(swas_pkg::CMD_NACK, 6'd0, 1'b1, 1'b1);
      add_row(swas_pkg::CMD_ACK, 6'd63, 1'b1, 1'b1);
      add_row(swas_pkg::CMD_TIMEOUT, 6'd0, 1'b1, 1'b0);
      add_row(swas_pkg::CMD_START, 6'd0, 1'b1, 1'b0);
      add_cfg(6'd63, 24'd0);
      add_row(swas_pkg::CMD_START, 6'd21, 1'b1, 1'b0);
      // size below range, fewer frames than slots
      add_cfg(6'd0, 24'd3);
      add_row(swas_pkg::CMD_START, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd1);
      add_row(swas_pkg::CMD_NACK, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd50);
      add_row(swas_pkg::CMD_ACK, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd17);
      add_row(swas_pkg::CMD_NACK, 6'd0, 1'b1, 1'b1);
      // size above range, endless source
      add_cfg(6'd63, 24'hFFFFFF);
      add_row(swas_pkg::CMD_START, 6'd0);
      add_row(swas_pkg::CMD_TIMEOUT, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd5);
      add_row(swas_pkg::CMD_ACK, 6'd63);
      add_row(swas_pkg::CMD_NACK, 6'd0);
      // shrink the window over a full one
      add_cfg(6'd9, 24'hFFFFFF);
      add_row(swas_pkg::CMD_TIMEOUT, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd32);
      add_row(swas_pkg::CMD_NACK, 6'd42);
      // largest window, restart over a live one
      add_cfg(6'd32, 24'd40);
      add_row(swas_pkg::CMD_START, 6'd0);
      add_row(swas_pkg::CMD_START, 6'd63);
      add_row(swas_pkg::CMD_ACK, 6'd0);
      add_row(swas_pkg::CMD_ACK, 6'd1);
      add_row(swas_pkg::CMD_TIMEOUT, 6'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_cfg) program_window(plan_rows[i].ws, plan_rows[i].tf);
         else drive_req(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].typed_done);
      end

      // random phases, each with its own window setting and idling pattern
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin
               ws = 6'd10;
               tf = 24'd30;
            end
            1: begin
               ws = 6'd32;
               tf = 24'hFFFFFF;
            end
            2: begin
               ws = swas_pkg::WIN_W'($urandom_range(0, 63));
               tf = swas_pkg::FRAME_W'($urandom_range(0, 120));
            end
            3: begin
               ws = 6'd63;
               tf = 24'd64;
            end
            4: begin
               ws = 6'd0;
               tf = swas_pkg::FRAME_W'($urandom_range(1, 9));
            end
            default: begin
               ws = swas_pkg::WIN_W'($urandom_range(11, 31));
               tf = swas_pkg::FRAME_W'($urandom_range(200, 24'hFFFFFF));
            end
         endcase
         program_window(ws, tf);
         if (ph < 2) begin
            sender_idle_pct    = 35;
            receiver_stall_pct = 56;
         end else if (ph < 4) begin
            sender_idle_pct    = 56;
            receiver_stall_pct = 35;
         end else begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            drained = 1'b1;
            for (int i = 0; i < span(); i++) if (slot_busy[i]) drained = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < (drained ? 75 : 4)) r.command = swas_pkg::CMD_START;
            else if (roll < 74)            r.command = swas_pkg::CMD_ACK;
            else if (roll < 86)            r.command = swas_pkg::CMD_NACK;
            else                           r.command = swas_pkg::CMD_TIMEOUT;
            r.ack_seq = (r.command == swas_pkg::CMD_ACK) ? pick_ack()
                                                         : swas_pkg::SEQ_W'($urandom_range(0, 63));
            drive_req(r, 1'b0, 1'b0);
         end
      end

      wait_drained();
      $display("ran %0d requests over %0d window settings, %0d response words checked",
               items_sent, RAND_PHASES + 5, words_checked);
      $display("seen %0d ack misses and %0d emptied windows", misses_seen, drains_seen);
      if (error_count == 0) begin
         $display("tb_sliding_window_arq_sender_top: clean");
      end else begin
         $display("tb_sliding_window_arq_sender_top: errors");
      end
      $finish;
   end

   // hard limit on run time
   initial begin
      #5_000_000;
      $display("tb_sliding_window_arq_sender_top: errors");
      $finish;
   end

endmodule
